// File: hdl/scf_pkg.sv
package scf_pkg;

  localparam int SP_W    = 14;
  localparam int BYTE_W  = 8;
  localparam int FRAME_N = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SP_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PACE_LIMIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_LOW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_HIGH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_CENTER   = 3'd6;

  // Reset values.
  localparam logic [7:0]      RST_DEADBAND        = 8'd30;
  localparam logic [5:0]      RST_HEARTBEAT_LIMIT = 6'd25;
  localparam logic [3:0]      RST_PACE_LIMIT      = 4'd2;
  localparam logic [SP_W-1:0] RST_PRESET_LOW      = 14'd50;
  localparam logic [SP_W-1:0] RST_PRESET_HIGH     = 14'd4000;
  localparam logic [SP_W-1:0] RST_PRESET_CENTER   = 14'd2000;
  localparam logic [SP_W-1:0] RST_SETPOINT        = 14'd2000;

  // Item kinds.
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_COMMAND = 1'b1;

  // Frame markers and substitutes.
  localparam logic [7:0] MK_PLAIN_A  = 8'hFD;
  localparam logic [7:0] MK_PLAIN_B  = 8'hFE;
  localparam logic [7:0] SUB_PLAIN   = 8'hFC;
  localparam logic [7:0] MK_RELAY_SO = 8'hF2;
  localparam logic [7:0] MK_RELAY_EO = 8'hFF;
  localparam logic [7:0] SUB_RELAY   = 8'hF0;
  localparam logic [7:0] RES_RELAY_1 = 8'hF1;
  localparam logic [7:0] RES_RELAY_3 = 8'hF3;

  typedef logic [FRAME_N-1:0][BYTE_W-1:0] frame_t;

  typedef struct packed {
    logic   load;
    frame_t bytes;
  } frame_load_t;

endpackage

// File: hdl/scf_core.sv
module scf_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr,
  input  logic [scf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_fire,
  input  logic                              in_kind,
  input  logic [7:0]                        in_rx_byte,
  output logic                              emit,
  output scf_pkg::frame_load_t              frame_out
);

  localparam logic [7:0] CMD_BOTH_AB  = 8'h61; // 'a'
  localparam logic [7:0] CMD_BOTH_BA  = 8'h64; // 'd'
  localparam logic [7:0] CMD_LOW      = 8'h77; // 'w'
  localparam logic [7:0] CMD_HIGH     = 8'h78; // 'x'
  localparam logic [7:0] CMD_CENTER   = 8'h73; // 's'
  localparam logic [7:0] CMD_ENTRY_A  = 8'h6C; // 'l'
  localparam logic [7:0] CMD_ENTRY_B  = 8'h72; // 'r'
  localparam logic [7:0] CMD_COMMIT_A = 8'h66; // 'f'
  localparam logic [7:0] CMD_COMMIT_B = 8'h67; // 'g'
  localparam logic [7:0] CHR_ZERO     = 8'h30;
  localparam logic [7:0] CHR_NINE     = 8'h39;
  localparam logic [2:0] LAST_DIGIT   = 3'd3;

  localparam int SP_W = scf_pkg::SP_W;

  logic            relay_mode_r, relay_mode_nxt;
  logic [7:0]      deadband_r, deadband_nxt;
  logic [5:0]      hb_limit_r, hb_limit_nxt;
  logic [3:0]      pace_limit_r, pace_limit_nxt;
  logic [SP_W-1:0] preset_low_r, preset_low_nxt;
  logic [SP_W-1:0] preset_high_r, preset_high_nxt;
  logic [SP_W-1:0] preset_center_r, preset_center_nxt;
  logic [SP_W-1:0] setpoint_a_r, setpoint_a_nxt;
  logic [SP_W-1:0] setpoint_b_r, setpoint_b_nxt;
  logic [SP_W-1:0] sent_a_r, sent_a_nxt;
  logic [SP_W-1:0] sent_b_r, sent_b_nxt;
  logic [5:0]      hb_count_r, hb_count_nxt;
  logic [3:0]      pace_count_r, pace_count_nxt;
  logic            change_pending_r, change_pending_nxt;
  logic            pace_pending_r, pace_pending_nxt;
  logic            entry_a_active_r, entry_a_active_nxt;
  logic            entry_b_active_r, entry_b_active_nxt;
  logic [2:0]      digit_index_r, digit_index_nxt;
  logic [SP_W-1:0] entry_a_value_r, entry_a_value_nxt;
  logic [SP_W-1:0] entry_b_value_r, entry_b_value_nxt;

  logic            hb_fire, pace_fire, moved_a, moved_b;
  logic            change_now, pace_now;
  logic [2:0]      idx_mid;
  logic [7:0]      al, ah, bl, bh;
  scf_pkg::frame_t frame;

  function automatic logic [SP_W-1:0] digit_term(input logic [7:0] c, input logic [1:0] idx);
    logic [3:0] dv;
    logic [9:0] w;
    begin
      if (c >= CHR_ZERO && c <= CHR_NINE) begin
        dv = c[3:0];
      end else if (c > CHR_NINE) begin
        dv = 4'd10;
      end else begin
        dv = 4'd11;
      end
      case (idx)
        2'd0: w = 10'd1000;
        2'd1: w = 10'd100;
        2'd2: w = 10'd10;
        2'd3: w = 10'd1;
        default: w = 10'd1;
      endcase
      digit_term = {10'b0, dv} * {4'b0, w};
    end
  endfunction

  function automatic logic moved(input logic [SP_W-1:0] now, input logic [SP_W-1:0] last,
                                 input logic [7:0] band);
    logic [SP_W-1:0] d;
    begin
      d = (now > last) ? (now - last) : (last - now);
      moved = d > {6'b0, band};
    end
  endfunction

  function automatic logic [7:0] fix_relay(input logic [7:0] b);
    fix_relay = (b == scf_pkg::RES_RELAY_1 || b == scf_pkg::MK_RELAY_SO ||
                 b == scf_pkg::RES_RELAY_3) ? scf_pkg::SUB_RELAY : b;
  endfunction

  function automatic logic [7:0] fix_plain(input logic [7:0] b);
    fix_plain = (b == scf_pkg::MK_PLAIN_A || b == scf_pkg::MK_PLAIN_B) ?
                scf_pkg::SUB_PLAIN : b;
  endfunction

  // Decision for a tick, taken from the state before the tick.
  assign hb_fire    = hb_count_r > hb_limit_r;
  assign pace_fire  = pace_count_r > pace_limit_r;
  assign moved_a    = moved(setpoint_a_r, sent_a_r, deadband_r);
  assign moved_b    = moved(setpoint_b_r, sent_b_r, deadband_r);
  assign change_now = change_pending_r | hb_fire | moved_a | moved_b;
  assign pace_now   = pace_pending_r | pace_fire;
  assign emit       = (in_kind == scf_pkg::KIND_TICK) && change_now && pace_now;

  assign al = setpoint_a_r[7:0];
  assign ah = {2'b0, setpoint_a_r[SP_W-1:8]};
  assign bl = setpoint_b_r[7:0];
  assign bh = {2'b0, setpoint_b_r[SP_W-1:8]};

  always_comb begin
    if (relay_mode_r) begin
      frame[0] = scf_pkg::MK_RELAY_SO;
      frame[1] = fix_relay(al);
      frame[2] = fix_relay(ah);
      frame[3] = fix_relay(bl);
      frame[4] = fix_relay(bh);
      frame[5] = scf_pkg::MK_RELAY_EO;
    end else begin
      frame[0] = scf_pkg::MK_PLAIN_A;
      frame[1] = fix_plain(al);
      frame[2] = fix_plain(ah);
      frame[3] = scf_pkg::MK_PLAIN_B;
      frame[4] = fix_plain(bl);
      frame[5] = fix_plain(bh);
    end
  end

  assign frame_out.load  = in_fire && emit;
  assign frame_out.bytes = frame;

  always_comb begin
    relay_mode_nxt     = relay_mode_r;
    deadband_nxt       = deadband_r;
    hb_limit_nxt       = hb_limit_r;
    pace_limit_nxt     = pace_limit_r;
    preset_low_nxt     = preset_low_r;
    preset_high_nxt    = preset_high_r;
    preset_center_nxt  = preset_center_r;
    setpoint_a_nxt     = setpoint_a_r;
    setpoint_b_nxt     = setpoint_b_r;
    sent_a_nxt         = sent_a_r;
    sent_b_nxt         = sent_b_r;
    hb_count_nxt       = hb_count_r;
    pace_count_nxt     = pace_count_r;
    change_pending_nxt = change_pending_r;
    pace_pending_nxt   = pace_pending_r;
    entry_a_active_nxt = entry_a_active_r;
    entry_b_active_nxt = entry_b_active_r;
    digit_index_nxt    = digit_index_r;
    entry_a_value_nxt  = entry_a_value_r;
    entry_b_value_nxt  = entry_b_value_r;
    idx_mid            = digit_index_r;

    if (cfg_wr) begin
      case (cfg_index)
        scf_pkg::CFG_RELAY_MODE:      relay_mode_nxt    = cfg_data[0];
        scf_pkg::CFG_DEADBAND:        deadband_nxt      = cfg_data[7:0];
        scf_pkg::CFG_HEARTBEAT_LIMIT: hb_limit_nxt      = cfg_data[5:0];
        scf_pkg::CFG_PACE_LIMIT:      pace_limit_nxt    = cfg_data[3:0];
        scf_pkg::CFG_PRESET_LOW:      preset_low_nxt    = cfg_data;
        scf_pkg::CFG_PRESET_HIGH:     preset_high_nxt   = cfg_data;
        scf_pkg::CFG_PRESET_CENTER:   preset_center_nxt = cfg_data;
        default: ;
      endcase
    end

    if (in_fire && in_kind == scf_pkg::KIND_COMMAND) begin
      case (in_rx_byte)
        CMD_BOTH_AB: begin
          setpoint_a_nxt = preset_low_r;
          setpoint_b_nxt = preset_high_r;
        end
        CMD_BOTH_BA: begin
          setpoint_a_nxt = preset_high_r;
          setpoint_b_nxt = preset_low_r;
        end
        CMD_LOW: begin
          setpoint_a_nxt = preset_low_r;
          setpoint_b_nxt = preset_low_r;
        end
        CMD_HIGH: begin
          setpoint_a_nxt = preset_high_r;
          setpoint_b_nxt = preset_high_r;
        end
        CMD_CENTER: begin
          setpoint_a_nxt = preset_center_r;
          setpoint_b_nxt = preset_center_r;
        end
        CMD_ENTRY_A: begin
          entry_a_active_nxt = 1'b1;
          digit_index_nxt    = 3'd0;
        end
        CMD_ENTRY_B: begin
          entry_b_active_nxt = 1'b1;
          digit_index_nxt    = 3'd0;
        end
        CMD_COMMIT_A: begin
          entry_a_active_nxt = 1'b0;
          digit_index_nxt    = 3'd0;
          setpoint_a_nxt     = entry_a_value_r;
          entry_a_value_nxt  = '0;
        end
        CMD_COMMIT_B: begin
          entry_b_active_nxt = 1'b0;
          digit_index_nxt    = 3'd0;
          setpoint_b_nxt     = entry_b_value_r;
          entry_b_value_nxt  = '0;
        end
        default: begin
          // With both entries open, A takes the digit first and B the next place.
          if (digit_index_r <= LAST_DIGIT) begin
            if (entry_a_active_r) begin
              entry_a_value_nxt = entry_a_value_r + digit_term(in_rx_byte, digit_index_r[1:0]);
              idx_mid           = digit_index_r + 3'd1;
            end
            digit_index_nxt = idx_mid;
            if (entry_b_active_r) begin
              if (idx_mid <= LAST_DIGIT) begin
                entry_b_value_nxt = entry_b_value_r + digit_term(in_rx_byte, idx_mid[1:0]);
              end
              digit_index_nxt = idx_mid + 3'd1;
            end
            if (!entry_a_active_r && !entry_b_active_r) begin
              digit_index_nxt = 3'd0;
            end
          end
        end
      endcase
    end

    if (in_fire && in_kind == scf_pkg::KIND_TICK) begin
      hb_count_nxt       = hb_fire ? 6'd0 : hb_count_r + 6'd1;
      pace_count_nxt     = pace_fire ? 4'd0 : pace_count_r + 4'd1;
      change_pending_nxt = change_now;
      pace_pending_nxt   = pace_now;
      if (emit) begin
        sent_a_nxt         = setpoint_a_r;
        sent_b_nxt         = setpoint_b_r;
        change_pending_nxt = 1'b0;
        pace_pending_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_mode_r     <= 1'b0;
      deadband_r       <= scf_pkg::RST_DEADBAND;
      hb_limit_r       <= scf_pkg::RST_HEARTBEAT_LIMIT;
      pace_limit_r     <= scf_pkg::RST_PACE_LIMIT;
      preset_low_r     <= scf_pkg::RST_PRESET_LOW;
      preset_high_r    <= scf_pkg::RST_PRESET_HIGH;
      preset_center_r  <= scf_pkg::RST_PRESET_CENTER;
      setpoint_a_r     <= scf_pkg::RST_SETPOINT;
      setpoint_b_r     <= scf_pkg::RST_SETPOINT;
      sent_a_r         <= scf_pkg::RST_SETPOINT;
      sent_b_r         <= scf_pkg::RST_SETPOINT;
      hb_count_r       <= '0;
      pace_count_r     <= '0;
      change_pending_r <= 1'b0;
      pace_pending_r   <= 1'b0;
      entry_a_active_r <= 1'b0;
      entry_b_active_r <= 1'b0;
      digit_index_r    <= '0;
      entry_a_value_r  <= '0;
      entry_b_value_r  <= '0;
    end else begin
      relay_mode_r     <= relay_mode_nxt;
      deadband_r       <= deadband_nxt;
      hb_limit_r       <= hb_limit_nxt;
      pace_limit_r     <= pace_limit_nxt;
      preset_low_r     <= preset_low_nxt;
      preset_high_r    <= preset_high_nxt;
      preset_center_r  <= preset_center_nxt;
      setpoint_a_r     <= setpoint_a_nxt;
      setpoint_b_r     <= setpoint_b_nxt;
      sent_a_r         <= sent_a_nxt;
      sent_b_r         <= sent_b_nxt;
      hb_count_r       <= hb_count_nxt;
      pace_count_r     <= pace_count_nxt;
      change_pending_r <= change_pending_nxt;
      pace_pending_r   <= pace_pending_nxt;
      entry_a_active_r <= entry_a_active_nxt;
      entry_b_active_r <= entry_b_active_nxt;
      digit_index_r    <= digit_index_nxt;
      entry_a_value_r  <= entry_a_value_nxt;
      entry_b_value_r  <= entry_b_value_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_flags_clear_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    frame_out.load |=> !change_pending_r && !pace_pending_r)
    else $error("pending flags survived a sent frame");

  a_sent_follows_setpoint: assert property (@(posedge clk) disable iff (!rst_n)
    frame_out.load |=> sent_a_r == $past(setpoint_a_r) && sent_b_r == $past(setpoint_b_r))
    else $error("sent values not recorded with the frame");

  a_digit_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    digit_index_r <= 3'd5)
    else $error("digit index ran past the entry width");
`endif

endmodule

// File: hdl/scf_tx.sv
module scf_tx (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scf_pkg::frame_load_t frame_in,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_frame_byte,
  output logic                 out_frame_end
);

  localparam logic [2:0] FRAME_LEN = 3'(scf_pkg::FRAME_N);

  scf_pkg::frame_t buf_r, buf_nxt;
  logic [2:0]      left_r, left_nxt;
  logic            take;

  assign out_valid      = left_r != 3'd0;
  assign out_frame_byte = buf_r[0];
  assign out_frame_end  = left_r == 3'd1;
  assign take           = out_valid && out_ready;
  // A new frame may land in the same cycle that the last word of the old one leaves.
  assign free           = !out_valid || (take && out_frame_end);

  always_comb begin
    buf_nxt  = buf_r;
    left_nxt = left_r;
    if (take) begin
      buf_nxt  = buf_r >> scf_pkg::BYTE_W;
      left_nxt = left_r - 3'd1;
    end
    if (frame_in.load) begin
      buf_nxt  = frame_in.bytes;
      left_nxt = FRAME_LEN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    frame_in.load |-> free)
    else $error("frame loaded over one still in flight");

  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= FRAME_LEN)
    else $error("word count beyond frame length");

  a_load_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    frame_in.load |=> out_valid && left_r == FRAME_LEN)
    else $error("loaded frame not presented");
`endif

endmodule

// File: hdl/setpoint_change_framer.sv
// Channel  Direction  Signals
// in       input      in_valid, in_ready, in_kind, in_rx_byte
// out      output     out_valid, out_ready, out_frame_byte, out_frame_end
// cfg      input      cfg_valid, cfg_ready, cfg_index, cfg_data
//
// A command word or a tick is taken when in_valid and in_ready are both high and updates state at that edge.
// A tick that sends a frame loads six words into the output shift register, which
// then gives one word per cycle while out_ready is high.
// in_ready drops only for a frame-sending tick while the previous frame still has
// words waiting, unless its last word leaves in that same cycle; commands and quiet
// ticks pass every cycle.
// rst_n is synchronous and active low; cfg_ready is always high.
module setpoint_change_framer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_frame_byte,
  output logic                           out_frame_end,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [scf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scf_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                 emit;
  logic                 tx_free;
  logic                 in_fire;
  scf_pkg::frame_load_t frame;

  assign cfg_ready = 1'b1;
  assign in_ready  = !emit || tx_free;
  assign in_fire   = in_valid && in_ready;

  scf_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_fire    (in_fire),
    .in_kind    (in_kind),
    .in_rx_byte (in_rx_byte),
    .emit       (emit),
    .frame_out  (frame)
  );

  scf_tx u_tx (
    .clk            (clk),
    .rst_n          (rst_n),
    .frame_in       (frame),
    .free           (tx_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end)
  );

endmodule

// File: dv/tb_setpoint_change_framer.sv
module tb_setpoint_change_framer;
  timeunit 1ns;
  timeprecision 1ps;

  import scf_pkg::*;

  // Command letters understood by the block.
  localparam logic [7:0] CMD_SPLIT      = "a";
  localparam logic [7:0] CMD_SPLIT_SWAP = "d";
  localparam logic [7:0] CMD_BOTH_LOW   = "w";
  localparam logic [7:0] CMD_BOTH_HIGH  = "x";
  localparam logic [7:0] CMD_CENTER     = "s";
  localparam logic [7:0] CMD_EDIT_A     = "l";
  localparam logic [7:0] CMD_EDIT_B     = "r";
  localparam logic [7:0] CMD_COMMIT_A   = "f";
  localparam logic [7:0] CMD_COMMIT_B   = "g";
  localparam logic [7:0] DIGIT_ZERO     = "0";
  localparam logic [7:0] DIGIT_NINE     = "9";
  localparam logic [7:0] SCRIPT_TICK    = " ";

  typedef struct {
    logic       kind;
    logic [7:0] rx_byte;
    bit         hold;
  } in_item_t;

  typedef struct {
    logic [7:0] data;
    logic       is_last;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, in_kind;
  logic [7:0] in_rx_byte;
  logic out_valid, out_ready, out_frame_end;
  logic [7:0] out_frame_byte;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  setpoint_change_framer u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t    feed[$];
  frame_word_t frame_words_due[$];
  bit hold_next = 1'b0;
  bit in_taken = 1'b0, out_taken = 1'b0, cfg_taken = 1'b0;
  bit in_idle = 1'b1, all_quiet = 1'b1;
  int in_gap = 0, out_stall = 0, in_calm = 0, out_calm = 0;
  int errors = 0;

  // Predicted configuration and state of the block.
  logic            relay_on;
  logic [7:0]      band;
  logic [5:0]      hb_lim;
  logic [3:0]      pace_lim;
  logic [SP_W-1:0] pre_lo, pre_hi, pre_mid;
  logic [SP_W-1:0] sp_a, sp_b, last_a, last_b, acc_a, acc_b;
  logic [5:0]      hb_cnt;
  logic [3:0]      pace_cnt;
  logic            chg_flag, pace_flag, edit_a, edit_b;
  logic [2:0]      dig_pos;

  function automatic void model_reset();
    relay_on = 1'b0;
    band     = RST_DEADBAND;
    hb_lim   = RST_HEARTBEAT_LIMIT;
    pace_lim = RST_PACE_LIMIT;
    pre_lo   = RST_PRESET_LOW;
    pre_hi   = RST_PRESET_HIGH;
    pre_mid  = RST_PRESET_CENTER;
    sp_a = RST_SETPOINT;
    sp_b = RST_SETPOINT;
    last_a = RST_SETPOINT;
    last_b = RST_SETPOINT;
    acc_a = '0;
    acc_b = '0;
    hb_cnt = '0;
    pace_cnt = '0;
    chg_flag = 1'b0;
    pace_flag = 1'b0;
    edit_a = 1'b0;
    edit_b = 1'b0;
    dig_pos = '0;
  endfunction

  function automatic void cfg_store(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_RELAY_MODE:      relay_on = val[0];
      CFG_DEADBAND:        band = val[7:0];
      CFG_HEARTBEAT_LIMIT: hb_lim = val[5:0];
      CFG_PACE_LIMIT:      pace_lim = val[3:0];
      CFG_PRESET_LOW:      pre_lo = val;
      CFG_PRESET_HIGH:     pre_hi = val;
      CFG_PRESET_CENTER:   pre_mid = val;
      default: ;
    endcase
  endfunction

  // Contribution of one entered character at a digit position; characters
  // above '9' count as ten and those below '0' as eleven.
  function automatic logic [SP_W-1:0] digit_term(logic [7:0] c, logic [2:0] pos);
    int v, w;
    if (c >= DIGIT_ZERO && c <= DIGIT_NINE) v = int'(c - DIGIT_ZERO);
    else if (c > DIGIT_NINE) v = 10;
    else v = 11;
    case (pos[1:0])
      2'd0: w = 1000;
      2'd1: w = 100;
      2'd2: w = 10;
      default: w = 1;
    endcase
    return SP_W'(v * w);
  endfunction

  function automatic void track_command(logic [7:0] c);
    case (c)
      CMD_SPLIT: begin
        sp_a = pre_lo;
        sp_b = pre_hi;
      end
      CMD_SPLIT_SWAP: begin
        sp_a = pre_hi;
        sp_b = pre_lo;
      end
      CMD_BOTH_LOW: begin
        sp_a = pre_lo;
        sp_b = pre_lo;
      end
      CMD_BOTH_HIGH: begin
        sp_a = pre_hi;
        sp_b = pre_hi;
      end
      CMD_CENTER: begin
        sp_a = pre_mid;
        sp_b = pre_mid;
      end
      CMD_EDIT_A: begin
        edit_a = 1'b1;
        dig_pos = '0;
      end
      CMD_EDIT_B: begin
        edit_b = 1'b1;
        dig_pos = '0;
      end
      CMD_COMMIT_A: begin
        edit_a = 1'b0;
        dig_pos = '0;
        sp_a = acc_a;
        acc_a = '0;
      end
      CMD_COMMIT_B: begin
        edit_b = 1'b0;
        dig_pos = '0;
        sp_b = acc_b;
        acc_b = '0;
      end
      default: begin
        // With both entries open, one character feeds A and then B at the
        // next position.
        if (dig_pos <= 3'd3) begin
          if (edit_a) begin
            acc_a = acc_a + digit_term(c, dig_pos);
            dig_pos = dig_pos + 3'd1;
          end
          if (edit_b) begin
            if (dig_pos <= 3'd3) acc_b = acc_b + digit_term(c, dig_pos);
            dig_pos = dig_pos + 3'd1;
          end
          if (!edit_a && !edit_b) dig_pos = '0;
        end
      end
    endcase
  endfunction

  function automatic logic [SP_W-1:0] sp_gap(logic [SP_W-1:0] a, logic [SP_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [7:0] relay_safe(logic [7:0] b);
    return (b == RES_RELAY_1 || b == MK_RELAY_SO || b == RES_RELAY_3) ? SUB_RELAY : b;
  endfunction

  function automatic logic [7:0] plain_safe(logic [7:0] b);
    return (b == MK_PLAIN_A || b == MK_PLAIN_B) ? SUB_PLAIN : b;
  endfunction

  function automatic void tick_and_frame();
    logic [7:0] fb [FRAME_N];
    logic [7:0] al, ah, bl, bh;
    if (hb_cnt > hb_lim) begin
      chg_flag = 1'b1;
      hb_cnt = '0;
    end else begin
      hb_cnt = hb_cnt + 6'd1;
    end
    if (pace_cnt > pace_lim) begin
      pace_flag = 1'b1;
      pace_cnt = '0;
    end else begin
      pace_cnt = pace_cnt + 4'd1;
    end
    if (sp_gap(sp_a, last_a) > SP_W'(band) || sp_gap(sp_b, last_b) > SP_W'(band))
      chg_flag = 1'b1;
    if (chg_flag && pace_flag) begin
      al = sp_a[7:0];
      ah = 8'(sp_a[SP_W-1:8]);
      bl = sp_b[7:0];
      bh = 8'(sp_b[SP_W-1:8]);
      if (relay_on) begin
        fb = '{MK_RELAY_SO, relay_safe(al), relay_safe(ah), relay_safe(bl), relay_safe(bh),
               MK_RELAY_EO};
      end else begin
        fb = '{MK_PLAIN_A, plain_safe(al), plain_safe(ah), MK_PLAIN_B, plain_safe(bl),
               plain_safe(bh)};
      end
      for (int k = 0; k < FRAME_N; k++) frame_words_due.push_back('{fb[k], k == FRAME_N - 1});
      last_a = sp_a;
      last_b = sp_b;
      chg_flag = 1'b0;
      pace_flag = 1'b0;
    end
  endfunction

  // Wait draw with occasional stretches of back-to-back traffic.
  function automatic int idle_draw(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  always @(negedge clk) begin : drive_in
    in_item_t it;
    logic     nxt_valid;
    if (rst_n) begin
      nxt_valid = in_valid;
      if (in_valid && in_taken) begin
        nxt_valid = 1'b0;
        in_gap = idle_draw(in_calm);
      end
      if (!nxt_valid) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (feed.size() != 0 && !(feed[0].hold && frame_words_due.size() != 0)) begin
          it = feed.pop_front();
          nxt_valid = 1'b1;
          in_kind <= it.kind;
          in_rx_byte <= it.rx_byte;
        end
      end
      in_valid <= nxt_valid;
      in_idle = !nxt_valid && feed.size() == 0;
    end
  end

  always @(negedge clk) begin : drive_out
    if (rst_n) begin
      if (out_taken) out_stall = idle_draw(out_calm);
      if (out_stall != 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch
    frame_word_t w;
    in_taken = 1'b0;
    out_taken = 1'b0;
    cfg_taken = 1'b0;
    if (!rst_n) begin
      model_reset();
    end else begin
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        if (frame_words_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, actual %02h end %0b",
                   $time, out_frame_byte, out_frame_end);
        end else begin
          w = frame_words_due.pop_front();
          if (out_frame_byte !== w.data) begin
            errors++;
            $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                     $time, w.data, out_frame_byte);
          end
          if (out_frame_end !== w.is_last) begin
            errors++;
            $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                     $time, w.is_last, out_frame_end);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        cfg_taken = 1'b1;
        cfg_store(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        if (in_kind == KIND_COMMAND) track_command(in_rx_byte);
        else tick_and_frame();
      end
      all_quiet = in_idle && frame_words_due.size() == 0;
    end
  end

  task automatic push_item(logic kind, logic [7:0] b);
    feed.push_back('{kind, b, hold_next});
    hold_next = 1'b0;
  endtask

  task automatic push_tick();
    push_item(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  // In a script, a space stands for a tick and every other character is a command word.
  task automatic push_script(string s);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == SCRIPT_TICK) push_tick();
      else push_item(KIND_COMMAND, s[i]);
    end
  endtask

  task automatic push_random(int n);
    int base, pick, sel;
    base = feed.size();
    while (feed.size() - base < n) begin
      if ($urandom_range(0, 24) == 0) hold_next = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // Entry sequence: open, a few characters, then usually commit.
        sel = $urandom_range(0, 2);
        if (sel != 1) push_item(KIND_COMMAND, CMD_EDIT_A);
        if (sel != 0) push_item(KIND_COMMAND, CMD_EDIT_B);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 9) != 0)
            push_item(KIND_COMMAND, DIGIT_ZERO + 8'($urandom_range(0, 9)));
          else
            push_item(KIND_COMMAND, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 7) != 0) begin
          if (sel != 1) push_item(KIND_COMMAND, CMD_COMMIT_A);
          if (sel != 0) push_item(KIND_COMMAND, CMD_COMMIT_B);
        end
      end else if (pick < 55) begin
        case ($urandom_range(0, 4))
          0: push_item(KIND_COMMAND, CMD_SPLIT);
          1: push_item(KIND_COMMAND, CMD_SPLIT_SWAP);
          2: push_item(KIND_COMMAND, CMD_BOTH_LOW);
          3: push_item(KIND_COMMAND, CMD_BOTH_HIGH);
          default: push_item(KIND_COMMAND, CMD_CENTER);
        endcase
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) push_tick();
      end else begin
        push_item(KIND_COMMAND, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic mode, logic [7:0] db, logic [5:0] hb, logic [3:0] pace,
                          logic [SP_W-1:0] lo, logic [SP_W-1:0] hi, logic [SP_W-1:0] mid);
    write_reg(CFG_RELAY_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_DEADBAND, CFG_DATA_W'(db));
    write_reg(CFG_HEARTBEAT_LIMIT, CFG_DATA_W'(hb));
    write_reg(CFG_PACE_LIMIT, CFG_DATA_W'(pace));
    write_reg(CFG_PRESET_LOW, lo);
    write_reg(CFG_PRESET_HIGH, hi);
    write_reg(CFG_PRESET_CENTER, mid);
    @(posedge clk);
  endtask

  // Waits until every word is sent and every frame word has arrived, then lets
  // the last command settle.
  task automatic wait_idle();
    repeat (2) @(posedge clk);
    do @(negedge clk); while (!all_quiet);
    repeat (4) @(negedge clk);
  endtask

  // Presets often carry a low byte that collides with a frame marker.
  function automatic logic [SP_W-1:0] pick_preset();
    logic [7:0] lo;
    if ($urandom_range(0, 3) != 0) return SP_W'($urandom_range(0, 16383));
    case ($urandom_range(0, 4))
      0: lo = RES_RELAY_1;
      1: lo = MK_RELAY_SO;
      2: lo = RES_RELAY_3;
      3: lo = MK_PLAIN_A;
      default: lo = MK_PLAIN_B;
    endcase
    return {6'($urandom_range(0, 63)), lo};
  endfunction

  initial begin : run
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_TICK;
    in_rx_byte = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RELAY_MODE;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, plain layout: marker collisions, odd characters, digit overflow
    // past four places, shared entry and the preset letters a, d, w and x.
    set_regs(1'b0, 8'd0, 6'd0, 4'd0, 14'h00FD, 14'h3FFE, 14'h2000);
    push_script(" a l9:/07frl52gfxwd7  ");
    wait_idle();

    // Directed, relay layout with entry wrap-around.
    set_regs(1'b1, 8'd255, 6'd62, 4'd0, 14'h00F1, 14'h3FF2, 14'h00F3);
    push_script("s a  l::::l:f  ");
    wait_idle();

    set_regs(1'b0, RST_DEADBAND, RST_HEARTBEAT_LIMIT, RST_PACE_LIMIT, RST_PRESET_LOW,
             RST_PRESET_HIGH, RST_PRESET_CENTER);
    push_random(50);
    wait_idle();

    set_regs(1'b1, 8'd0, 6'd62, 4'd14, 14'd0, 14'd16383, pick_preset());
    hold_next = 1'b1;
    push_random(45);
    wait_idle();

    repeat (4) begin
      set_regs(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
               6'($urandom_range(0, 8)), 4'($urandom_range(0, 3)),
               pick_preset(), pick_preset(), pick_preset());
      push_random(30);
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("setpoint_change_framer regression: pass");
    end else begin
      $display("setpoint_change_framer regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("setpoint_change_framer regression: fail");
    $finish;
  end

endmodule
